/* hw/rtl/sbfu_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbfu_pkg
// shared widths and types of the spring and bungee force unit
// ----------------------------------------------------------------------------
package sbfu_pkg;

	localparam int POS_W   = 32;
	localparam int COEF_W  = 31;
	localparam int DMAG_W  = 33;
	localparam int SUM_W   = 67;
	localparam int LEN_W   = 35;
	localparam int QW      = 32;

	localparam logic [QW-1:0] SAT_POS = 32'h7FFF_FFFF;
	localparam logic [QW-1:0] SAT_NEG = 32'h8000_0000;

	localparam logic MODE_SPRING = 1'b0;
	localparam logic MODE_BUNGEE = 1'b1;

	// payload that rides along the square root pipeline
	typedef struct packed {
		logic                          cmd;
		logic [COEF_W-1:0]             k;
		logic [COEF_W-1:0]             rest;
		logic [2:0][DMAG_W-1:0]        dmag;
		logic [2:0]                    dneg;
	} sqrt_side_t;

	// payload that rides along one divider lane
	typedef struct packed {
		logic kill;
		logic neg;
		logic ovf;
	} div_side_t;

endpackage

/* hw/rtl/sbfu_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbfu_if
// item channels of the spring and bungee force unit
// ----------------------------------------------------------------------------
interface sbfu_query_if;
	logic               valid;
	logic               ready;
	logic               cmd;
	logic signed [31:0] self_x;
	logic signed [31:0] self_y;
	logic signed [31:0] self_z;
	logic signed [31:0] other_x;
	logic signed [31:0] other_y;
	logic signed [31:0] other_z;
	logic [30:0]        stiffness;
	logic [30:0]        rest_len;

	modport source (output valid, cmd, self_x, self_y, self_z, other_x, other_y, other_z,
		stiffness, rest_len, input ready);
	modport sink (input valid, cmd, self_x, self_y, self_z, other_x, other_y, other_z,
		stiffness, rest_len, output ready);
endinterface

interface sbfu_result_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] force_x;
	logic signed [31:0] force_y;
	logic signed [31:0] force_z;
	logic               applied;
	logic               clipped;

	modport source (output valid, force_x, force_y, force_z, applied, clipped, input ready);
	modport sink (input valid, force_x, force_y, force_z, applied, clipped, output ready);
endinterface

/* hw/rtl/sbfu_sqrt.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbfu_sqrt
// pipelined integer square root, one result bit per stage
// ----------------------------------------------------------------------------
module sbfu_sqrt import sbfu_pkg::*; #(
	parameter int SW = 1
) (
	input  logic             clk,
	input  logic             adv,
	input  logic [SUM_W-1:0] rad,
	input  logic [SW-1:0]    side_in,
	output logic [LEN_W-1:0] root,
	output logic [SW-1:0]    side_out
);

	localparam int RADW = 2 * LEN_W;
	localparam int RW   = LEN_W + 3;

	logic [RADW-1:0]  rad_s  [LEN_W];
	logic [RW-1:0]    rem_s  [LEN_W];
	logic [LEN_W-1:0] root_s [LEN_W];
	logic [SW-1:0]    side_s [LEN_W];

	for (genvar g = 0; g < LEN_W; g++) begin : g_stage
		logic [RADW-1:0]  rad_c;
		logic [RW-1:0]    rem_c;
		logic [LEN_W-1:0] root_c;
		logic [SW-1:0]    side_c;
		logic [RW-1:0]    cur;
		logic [RW-1:0]    trial;
		logic             ge;

		if (g == 0) begin : g_first
			assign rad_c  = RADW'(rad);
			assign rem_c  = '0;
			assign root_c = '0;
			assign side_c = side_in;
		end else begin : g_rest
			assign rad_c  = rad_s[g-1];
			assign rem_c  = rem_s[g-1];
			assign root_c = root_s[g-1];
			assign side_c = side_s[g-1];
		end

		// bring down the next pair of radicand bits
		assign cur   = {rem_c[RW-3:0], rad_c[RADW-1-2*g -: 2]};
		assign trial = RW'({root_c, 2'b01});
		assign ge    = cur >= trial;

		always_ff @(posedge clk) begin
			if (adv) begin
				rad_s[g]  <= rad_c;
				rem_s[g]  <= ge ? cur - trial : cur;
				root_s[g] <= {root_c[LEN_W-2:0], ge};
				side_s[g] <= side_c;
			end
		end
	end

	assign root     = root_s[LEN_W-1];
	assign side_out = side_s[LEN_W-1];

endmodule

/* hw/rtl/sbfu_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbfu_div
// pipelined restoring divider lane, one quotient bit per stage
// ----------------------------------------------------------------------------
module sbfu_div import sbfu_pkg::*; #(
	parameter int SW = 1
) (
	input  logic             clk,
	input  logic             adv,
	input  logic [LEN_W-1:0] den,
	input  logic [LEN_W-1:0] rem0,
	input  logic [QW-1:0]    low,
	input  logic [SW-1:0]    side_in,
	output logic [QW-1:0]    quo,
	output logic [SW-1:0]    side_out
);

	localparam int RW = LEN_W + 1;

	logic [LEN_W-1:0] den_s  [QW];
	logic [LEN_W-1:0] rem_s  [QW];
	logic [QW-1:0]    low_s  [QW];
	logic [QW-1:0]    quo_s  [QW];
	logic [SW-1:0]    side_s [QW];

	for (genvar g = 0; g < QW; g++) begin : g_stage
		logic [LEN_W-1:0] den_c;
		logic [LEN_W-1:0] rem_c;
		logic [QW-1:0]    low_c;
		logic [QW-1:0]    quo_c;
		logic [SW-1:0]    side_c;
		logic [RW-1:0]    cur;
		logic [RW-1:0]    diff;
		logic             ge;

		if (g == 0) begin : g_first
			assign den_c  = den;
			assign rem_c  = rem0;
			assign low_c  = low;
			assign quo_c  = '0;
			assign side_c = side_in;
		end else begin : g_rest
			assign den_c  = den_s[g-1];
			assign rem_c  = rem_s[g-1];
			assign low_c  = low_s[g-1];
			assign quo_c  = quo_s[g-1];
			assign side_c = side_s[g-1];
		end

		assign cur  = {rem_c, low_c[QW-1]};
		assign ge   = cur >= {1'b0, den_c};
		assign diff = cur - {1'b0, den_c};

		always_ff @(posedge clk) begin
			if (adv) begin
				den_s[g]  <= den_c;
				rem_s[g]  <= ge ? diff[LEN_W-1:0] : cur[LEN_W-1:0];
				low_s[g]  <= {low_c[QW-2:0], 1'b0};
				quo_s[g]  <= {quo_c[QW-2:0], ge};
				side_s[g] <= side_c;
			end
		end
	end

	assign quo      = quo_s[QW-1];
	assign side_out = side_s[QW-1];

endmodule

/* hw/rtl/spring_bungee_force_unit.sv */
`timescale 1ns / 1ps
// an accepted item passes the front stages, the square root, the middle stages, the divider lanes and the output stage
// throughput: one item per cycle; the whole pipeline holds while a result waits
// the 35-stage square root and the three 32-stage divider lanes set the depth
// reset clears all stage valid bits; payload registers are not reset
// ----------------------------------------------------------------------------
// spring_bungee_force_unit
// hooke spring / bungee force from two body positions, saturated q16.16
// ----------------------------------------------------------------------------
module spring_bungee_force_unit import sbfu_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	sbfu_query_if.sink      query,
	sbfu_result_if.source   result
);

	localparam int DEPTH = 3 + LEN_W + 6 + QW + 1;
	localparam int PW    = COEF_W + LEN_W;
	localparam int MW    = PW - FRAC_BITS;
	localparam int H     = (MW + 1) / 2;
	localparam int MH    = MW - H;
	localparam int NW    = MW + DMAG_W;
	localparam int ESW   = LEN_W + 1;

	logic             adv;
	logic [DEPTH-1:0] vld_q;

	assign adv          = !vld_q[DEPTH-1] || result.ready;
	assign query.ready  = adv;
	assign result.valid = vld_q[DEPTH-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[DEPTH-2:0], query.valid};
		end
	end

	// stage 1: differences
	logic signed [DMAG_W-1:0] d_c [3];
	logic [2:0][DMAG_W-1:0]   dmag_s1;
	logic [2:0]               dneg_s1;
	logic                     cmd_s1;
	logic [COEF_W-1:0]        k_s1;
	logic [COEF_W-1:0]        rest_s1;

	assign d_c[0] = DMAG_W'(query.self_x) - DMAG_W'(query.other_x);
	assign d_c[1] = DMAG_W'(query.self_y) - DMAG_W'(query.other_y);
	assign d_c[2] = DMAG_W'(query.self_z) - DMAG_W'(query.other_z);

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				dneg_s1[i] <= d_c[i][DMAG_W-1];
				dmag_s1[i] <= d_c[i][DMAG_W-1] ? DMAG_W'(-d_c[i]) : DMAG_W'(d_c[i]);
			end
			cmd_s1  <= query.cmd;
			k_s1    <= query.stiffness;
			rest_s1 <= query.rest_len;
		end
	end

	// stage 2: squares; a magnitude of 2^32 has a zero low word
	logic [2*QW:0]      sq_s2 [3];
	sqrt_side_t         side_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				sq_s2[i] <= dmag_s1[i][DMAG_W-1] ? {1'b1, {(2*QW){1'b0}}}
					: (2*QW+1)'(dmag_s1[i][QW-1:0] * dmag_s1[i][QW-1:0]);
			end
			side_s2.cmd  <= cmd_s1;
			side_s2.k    <= k_s1;
			side_s2.rest <= rest_s1;
			side_s2.dmag <= dmag_s1;
			side_s2.dneg <= dneg_s1;
		end
	end

	// stage 3: sum of squares
	logic [SUM_W-1:0] sum_s3;
	sqrt_side_t       side_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			sum_s3  <= SUM_W'(sq_s2[0]) + SUM_W'(sq_s2[1]) + SUM_W'(sq_s2[2]);
			side_s3 <= side_s2;
		end
	end

	logic [LEN_W-1:0] len_c;
	sqrt_side_t       sside_c;

	sbfu_sqrt #(.SW($bits(sqrt_side_t))) u_sqrt (
		.clk      (clk),
		.adv      (adv),
		.rad      (sum_s3),
		.side_in  (side_s3),
		.root     (len_c),
		.side_out (sside_c)
	);

	// stage 4: length error and the zero / slack cases
	logic signed [ESW-1:0] e_c;
	logic [LEN_W-1:0]      len_s4;
	logic [LEN_W-1:0]      emag_s4;
	logic                  eneg_s4;
	logic                  kill_s4;
	logic [COEF_W-1:0]     k_s4;
	logic [2:0][DMAG_W-1:0] dmag_s4;
	logic [2:0]            dneg_s4;

	assign e_c = ESW'(len_c) - ESW'(sside_c.rest);

	always_ff @(posedge clk) begin
		if (adv) begin
			len_s4  <= len_c;
			eneg_s4 <= e_c[ESW-1];
			emag_s4 <= e_c[ESW-1] ? LEN_W'(-e_c) : LEN_W'(e_c);
			kill_s4 <= (len_c == '0)
				|| (sside_c.cmd == MODE_BUNGEE && len_c <= LEN_W'(sside_c.rest));
			k_s4    <= sside_c.k;
			dmag_s4 <= sside_c.dmag;
			dneg_s4 <= sside_c.dneg;
		end
	end

	// stage 5: k * |e| as two partial products
	logic [COEF_W+QW-1:0]          plo_s5;
	logic [COEF_W+LEN_W-QW-1:0]    phi_s5;
	logic [LEN_W-1:0]              len_s5;
	logic                          eneg_s5;
	logic                          kill_s5;
	logic [2:0][DMAG_W-1:0]        dmag_s5;
	logic [2:0]                    dneg_s5;

	always_ff @(posedge clk) begin
		if (adv) begin
			plo_s5  <= (COEF_W+QW)'(k_s4 * emag_s4[QW-1:0]);
			phi_s5  <= (COEF_W+LEN_W-QW)'(k_s4 * emag_s4[LEN_W-1:QW]);
			len_s5  <= len_s4;
			eneg_s5 <= eneg_s4;
			kill_s5 <= kill_s4;
			dmag_s5 <= dmag_s4;
			dneg_s5 <= dneg_s4;
		end
	end

	// stage 6: magnitude m
	logic [PW-1:0]          p_c;
	logic [MW-1:0]          m_s6;
	logic [LEN_W-1:0]       len_s6;
	logic                   eneg_s6;
	logic                   kill_s6;
	logic [2:0][DMAG_W-1:0] dmag_s6;
	logic [2:0]             dneg_s6;

	assign p_c = PW'(plo_s5) + (PW'(phi_s5) << QW);

	always_ff @(posedge clk) begin
		if (adv) begin
			m_s6    <= p_c[PW-1:FRAC_BITS];
			len_s6  <= len_s5;
			eneg_s6 <= eneg_s5;
			kill_s6 <= kill_s5;
			dmag_s6 <= dmag_s5;
			dneg_s6 <= dneg_s5;
		end
	end

	// stage 7: m * |d| partial products per lane
	logic [H+DMAG_W-1:0]  nlo_s7 [3];
	logic [MH+DMAG_W-1:0] nhi_s7 [3];
	logic [LEN_W-1:0]     len_s7;
	logic                 kill_s7;
	logic [2:0]           neg_s7;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				nlo_s7[i] <= (H+DMAG_W)'(m_s6[H-1:0] * dmag_s6[i]);
				nhi_s7[i] <= (MH+DMAG_W)'(m_s6[MW-1:H] * dmag_s6[i]);
				neg_s7[i] <= (eneg_s6 == dneg_s6[i]);
			end
			len_s7  <= len_s6;
			kill_s7 <= kill_s6;
		end
	end

	// stage 8: full numerators
	logic [NW-1:0]    n_s8 [3];
	logic [LEN_W-1:0] len_s8;
	logic             kill_s8;
	logic [2:0]       neg_s8;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				n_s8[i] <= NW'(nlo_s7[i]) + (NW'(nhi_s7[i]) << H);
			end
			len_s8  <= len_s7;
			kill_s8 <= kill_s7;
			neg_s8  <= neg_s7;
		end
	end

	// stage 9: quotient of 2^32 or more saturates anyway
	logic [LEN_W-1:0] len_s9;
	logic [LEN_W-1:0] rem0_s9 [3];
	logic [QW-1:0]    low_s9  [3];
	div_side_t        dside_s9 [3];

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				rem0_s9[i]       <= n_s8[i][QW+LEN_W-1:QW];
				low_s9[i]        <= n_s8[i][QW-1:0];
				dside_s9[i].ovf  <= n_s8[i][NW-1:QW] >= (NW-QW)'(len_s8);
				dside_s9[i].neg  <= neg_s8[i];
				dside_s9[i].kill <= kill_s8;
			end
			len_s9 <= len_s8;
		end
	end

	logic [QW-1:0] quo_c   [3];
	div_side_t     dside_c [3];

	for (genvar l = 0; l < 3; l++) begin : g_lane
		sbfu_div #(.SW($bits(div_side_t))) u_div (
			.clk      (clk),
			.adv      (adv),
			.den      (len_s9),
			.rem0     (rem0_s9[l]),
			.low      (low_s9[l]),
			.side_in  (dside_s9[l]),
			.quo      (quo_c[l]),
			.side_out (dside_c[l])
		);
	end

	// stage 10: sign, saturation and flags
	logic [QW-1:0] f_c   [3];
	logic [2:0]    nz_c;
	logic [2:0]    sat_c;
	logic [QW-1:0] f_s10 [3];
	logic          applied_s10;
	logic          clipped_s10;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			nz_c[i]  = !dside_c[i].kill && (dside_c[i].ovf || quo_c[i] != '0);
			sat_c[i] = dside_c[i].ovf
				|| (dside_c[i].neg ? quo_c[i] > SAT_NEG : quo_c[i] > SAT_POS);
			if (!nz_c[i]) begin
				f_c[i] = '0;
			end else if (sat_c[i]) begin
				f_c[i] = dside_c[i].neg ? SAT_NEG : SAT_POS;
			end else begin
				f_c[i] = dside_c[i].neg ? -quo_c[i] : quo_c[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				f_s10[i] <= f_c[i];
			end
			applied_s10 <= |nz_c;
			clipped_s10 <= |(nz_c & sat_c);
		end
	end

	assign result.force_x = f_s10[0];
	assign result.force_y = f_s10[1];
	assign result.force_z = f_s10[2];
	assign result.applied = applied_s10;
	assign result.clipped = clipped_s10;

endmodule

/* verif/spring_bungee_force_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spring_bungee_force_unit_tb
// drives spring and bungee items with random gaps, predicts each force with
// an exact wide-integer model and checks every result in order
// ----------------------------------------------------------------------------

class force_scoreboard;
	typedef struct packed {
		logic [31:0] fx;
		logic [31:0] fy;
		logic [31:0] fz;
		logic        applied;
		logic        clipped;
	} force_t;

	force_t pending[$];
	int     errors;

	function void note_query(logic mode, logic signed [31:0] sx, sy, sz, ox, oy, oz,
			logic [30:0] k, logic [30:0] rest);
		logic signed [33:0]  dv[3];
		logic [66:0]         sum;
		logic [69:0]         cand_sq;
		logic [34:0]         len, cand;
		logic signed [36:0]  err;
		logic [35:0]         emag;
		logic [66:0]         prod;
		logic [50:0]         mag;
		logic [127:0]        quo;
		logic [32:0]         dm;
		force_t              f;
		logic [31:0]         comp[3];
		dv[0] = 34'(sx) - 34'(ox);
		dv[1] = 34'(sy) - 34'(oy);
		dv[2] = 34'(sz) - 34'(oz);
		sum = '0;
		for (int i = 0; i < 3; i++) begin
			dm = dv[i] < 0 ? 33'(-dv[i]) : 33'(dv[i]);
			sum += 67'(dm) * 67'(dm);
			comp[i] = '0;
		end
		len = '0;
		for (int b = 34; b >= 0; b--) begin
			cand = len | (35'd1 << b);
			cand_sq = 70'(cand) * 70'(cand);
			if (cand_sq <= 70'(sum))
				len = cand;
		end
		f.applied = 1'b0;
		f.clipped = 1'b0;
		if (len != 0 && !(mode == sbfu_pkg::MODE_BUNGEE && len <= 35'(rest))) begin
			err = 37'(len) - 37'(rest);
			emag = err < 0 ? 36'(-err) : 36'(err);
			prod = 67'(k) * 67'(emag);
			mag = 51'(prod >> 16);
			for (int i = 0; i < 3; i++) begin
				dm = dv[i] < 0 ? 33'(-dv[i]) : 33'(dv[i]);
				quo = (128'(mag) * 128'(dm)) / 128'(len);
				if (quo == 0)
					continue;
				if ((err > 0 && dv[i] > 0) || (err < 0 && dv[i] < 0)) begin
					if (quo > 128'h8000_0000) begin
						quo = 128'h8000_0000;
						f.clipped = 1'b1;
					end
					comp[i] = 32'(-quo);
				end else begin
					if (quo > 128'h7FFF_FFFF) begin
						quo = 128'h7FFF_FFFF;
						f.clipped = 1'b1;
					end
					comp[i] = 32'(quo);
				end
				f.applied = 1'b1;
			end
		end
		f.fx = comp[0];
		f.fy = comp[1];
		f.fz = comp[2];
		pending.push_back(f);
	endfunction

	task report(string what, logic [31:0] got, logic [31:0] want);
		errors++;
		$display("mismatch %s: got %h expected %h", what, got, want);
	endtask

	task check_result(logic [31:0] fx, fy, fz, logic applied, clipped);
		force_t w;
		if (pending.size() == 0) begin
			report("unexpected item", 0, 0);
			return;
		end
		w = pending.pop_front();
		if (fx !== w.fx) report("force_x", fx, w.fx);
		if (fy !== w.fy) report("force_y", fy, w.fy);
		if (fz !== w.fz) report("force_z", fz, w.fz);
		if (applied !== w.applied) report("applied", 32'(applied), 32'(w.applied));
		if (clipped !== w.clipped) report("clipped", 32'(clipped), 32'(w.clipped));
	endtask
endclass

module spring_bungee_force_unit_tb import sbfu_pkg::*; ();

	localparam int LATENCY = 77;
	localparam int STALL_LIMIT = 2000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   idle_cycles = 0;

	sbfu_query_if  query();
	sbfu_result_if result();

	spring_bungee_force_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.query(query),
		.result(result)
	);

	force_scoreboard board = new();

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		query.valid = 1'b0;
		query.cmd = MODE_SPRING;
		query.self_x = '0;
		query.self_y = '0;
		query.self_z = '0;
		query.other_x = '0;
		query.other_y = '0;
		query.other_z = '0;
		query.stiffness = '0;
		query.rest_len = '0;
		result.ready = 1'b0;
	end

	function automatic logic [31:0] rand_pos(int scale);
		case (scale)
			0: return $urandom;
			1: return 32'(signed'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000);
			default: return 32'(signed'($urandom_range(0, 32'h0200_0000)) - 32'h0100_0000);
		endcase
	endfunction

	task send_query(logic mode, logic [31:0] sx, sy, sz, ox, oy, oz,
			logic [30:0] k, logic [30:0] rest);
		int gap;
		gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
		// valid stays high across back to back items
		if (gap != 0) begin
			query.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		query.valid <= 1'b1;
		query.cmd <= mode;
		query.self_x <= sx;
		query.self_y <= sy;
		query.self_z <= sz;
		query.other_x <= ox;
		query.other_y <= oy;
		query.other_z <= oz;
		query.stiffness <= k;
		query.rest_len <= rest;
		do @(posedge clk); while (!query.ready);
		board.note_query(mode, sx, sy, sz, ox, oy, oz, k, rest);
	endtask

	task send_random;
		int scale;
		logic [30:0] k, rest;
		scale = $urandom_range(0, 2);
		k = ($urandom_range(0, 9) == 0) ? 31'($urandom) : 31'($urandom_range(0, 32'h0004_0000));
		rest = ($urandom_range(0, 9) == 0) ? 31'($urandom) :
			31'($urandom_range(0, 32'h0080_0000));
		if ($urandom_range(0, 19) == 0)
			send_query(1'($urandom_range(0, 1)), rand_pos(0), rand_pos(0), rand_pos(0),
				rand_pos(0), rand_pos(0), rand_pos(0), 31'($urandom), 31'($urandom));
		else
			send_query(1'($urandom_range(0, 1)), rand_pos(scale), rand_pos(scale),
				rand_pos(scale), rand_pos(scale), rand_pos(scale), rand_pos(scale), k, rest);
	endtask

	// result side: random stall per item, with runs of no stall
	initial begin
		int stall;
		wait (arst_n);
		forever begin
			stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
			if (stall != 0) begin
				result.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result.ready <= 1'b1;
			do @(posedge clk); while (!result.valid);
			board.check_result(result.force_x, result.force_y, result.force_z,
				result.applied, result.clipped);
		end
	end

	always @(posedge clk) begin
		if ((query.valid && query.ready) || (result.valid && result.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// zero length
		send_query(MODE_SPRING, 32'h10000, 32'h20000, 32'h30000,
			32'h10000, 32'h20000, 32'h30000, 31'h10000, 31'h0);
		// spring compressed and stretched, at rest length
		send_query(MODE_SPRING, 32'h10000, 0, 0, 0, 0, 0, 31'h20000, 31'h20000);
		send_query(MODE_SPRING, 32'h30000, 0, 0, 0, 0, 0, 31'h20000, 31'h10000);
		send_query(MODE_SPRING, 0, 32'h20000, 0, 0, 0, 0, 31'h10000, 31'h20000);
		// bungee slack, taut, exactly at rest
		send_query(MODE_BUNGEE, 32'h10000, 0, 0, 0, 0, 0, 31'h20000, 31'h20000);
		send_query(MODE_BUNGEE, 0, 0, 32'hFFFD0000, 0, 0, 0, 31'h20000, 31'h10000);
		send_query(MODE_BUNGEE, 32'h20000, 0, 0, 0, 0, 0, 31'h20000, 31'h20000);
		// extremes of positions and coefficients, saturation
		send_query(MODE_SPRING, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
			32'h80000000, 32'h7FFFFFFF, 32'h80000000, 31'h7FFFFFFF, 31'h0);
		send_query(MODE_SPRING, 32'h80000000, 32'h7FFFFFFF, 32'h80000000,
			32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF);
		send_query(MODE_BUNGEE, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
			32'h80000000, 32'h80000000, 32'h80000000, 31'h7FFFFFFF, 31'h7FFFFFFF);
		send_query(MODE_SPRING, 32'h1, 0, 0, 0, 0, 0, 31'h7FFFFFFF, 31'h7FFFFFFF);
		send_query(MODE_SPRING, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h1, 0, 0, 0, 31'h1, 31'h0);
		send_query(MODE_SPRING, 32'h00050000, 32'hFFFB0000, 0, 0, 0, 0, 31'h0, 31'h0);
		send_query(MODE_SPRING, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
			32'h0, 32'h0, 32'h0, 31'h7FFFFFFF, 31'h0);
		repeat (650) send_random();
		query.valid <= 1'b0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (LATENCY + 20) @(posedge clk);
		if (board.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
